/* rtl/ctte_pkg.sv */
// ----------------------------------------------------------------------------
// ctte_pkg
// Shared types and constants for the cut truth table evaluator.
// ----------------------------------------------------------------------------
package ctte_pkg;

    localparam int ID_BITS     = 20;
    localparam int STORE_DEPTH = 16;
    localparam int IDX_BITS    = $clog2(STORE_DEPTH);
    localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);
    localparam int TT_BITS     = 16;
    localparam int LEAF_MAX    = 4;

    typedef logic [ID_BITS-1:0]  node_id_t;
    typedef logic [TT_BITS-1:0]  tt_t;
    typedef logic [IDX_BITS-1:0] slot_idx_t;
    typedef logic [CNT_BITS-1:0] slot_cnt_t;

    typedef enum logic [1:0] {
        CMD_LEAF = 2'd0,
        CMD_AND  = 2'd1,
        CMD_ROOT = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_LEAVES  = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input item
        logic lookup;  // key compare, table read
        logic exec;    // combine, insert, report
    } ctl_t;

    // Projection patterns of the four leaf variables
    localparam tt_t LEAF_PAT [LEAF_MAX] = '{16'hAAAA, 16'hCCCC, 16'hF0F0, 16'hFF00};

endpackage

/* rtl/ctte_ctrl.sv */
// ----------------------------------------------------------------------------
// ctte_ctrl
// Sequencer: capture, lookup and execute, one item at a time.
// ----------------------------------------------------------------------------
module ctte_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output ctte_pkg::ctl_t ctl
);
    import ctte_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                ctl.lookup = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* rtl/ctte_datapath.sv */
// ----------------------------------------------------------------------------
// ctte_datapath
// Key store with parallel compare, table memory, counters and result register.
// ----------------------------------------------------------------------------
module ctte_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctte_pkg::ctl_t             ctl,
    input  logic [1:0]                 cmd,
    input  logic [ctte_pkg::ID_BITS-1:0] node_id,
    input  logic [ctte_pkg::ID_BITS-1:0] left_id,
    input  logic                       left_inv,
    input  logic [ctte_pkg::ID_BITS-1:0] right_id,
    input  logic                       right_inv,
    output logic                       result_valid,
    output logic [ctte_pkg::TT_BITS-1:0] truth_table,
    output logic [1:0]                 status
);
    import ctte_pkg::*;

    // captured item
    cmd_t     cmd_reg;
    node_id_t node_reg;
    node_id_t left_reg;
    node_id_t right_reg;
    logic     linv_reg;
    logic     rinv_reg;

    // store
    node_id_t  slot_key_reg [STORE_DEPTH];
    tt_t       slot_mem     [STORE_DEPTH];
    slot_cnt_t fill_reg;
    slot_cnt_t fill_next;
    logic [2:0] leaf_reg;
    logic [2:0] leaf_next;
    status_t   err_reg;
    status_t   err_next;

    // lookup results
    logic      hit_n_reg, hit_l_reg, hit_r_reg;
    tt_t       rd_a_reg, rd_b_reg;

    logic [STORE_DEPTH-1:0] match_n, match_l, match_r;
    slot_idx_t idx_n, idx_l, idx_r, addr_a;

    // result
    logic    valid_reg;
    tt_t     tt_reg;
    status_t stat_reg;

    // execute-stage signals
    logic    do_insert;
    tt_t     ins_tab;
    tt_t     opnd_a, opnd_b;
    status_t code;
    status_t root_err;

    function automatic slot_idx_t first_set(input logic [STORE_DEPTH-1:0] m);
        slot_idx_t idx;
        idx = '0;
        for (int i = STORE_DEPTH - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = IDX_BITS'(i);
            end
        end
        return idx;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd_t'(cmd);
            node_reg  <= node_id;
            left_reg  <= left_id;
            right_reg <= right_id;
            linv_reg  <= left_inv;
            rinv_reg  <= right_inv;
        end
    end

    // parallel compare against the filled slots
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            match_n[i] = (CNT_BITS'(i) < fill_reg) && (slot_key_reg[i] == node_reg);
            match_l[i] = (CNT_BITS'(i) < fill_reg) && (slot_key_reg[i] == left_reg);
            match_r[i] = (CNT_BITS'(i) < fill_reg) && (slot_key_reg[i] == right_reg);
        end
        idx_n  = first_set(match_n);
        idx_l  = first_set(match_l);
        idx_r  = first_set(match_r);
        addr_a = (cmd_reg == CMD_ROOT) ? idx_n : idx_l;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.lookup)
        begin
            hit_n_reg <= |match_n;
            hit_l_reg <= |match_l;
            hit_r_reg <= |match_r;
            rd_a_reg  <= slot_mem[addr_a];
            rd_b_reg  <= slot_mem[idx_r];
        end
    end

    always_comb
    begin
        opnd_a    = rd_a_reg ^ {TT_BITS{linv_reg}};
        opnd_b    = rd_b_reg ^ {TT_BITS{rinv_reg}};
        do_insert = 1'b0;
        ins_tab   = opnd_a & opnd_b;
        code      = STAT_OK;
        fill_next = fill_reg;
        leaf_next = leaf_reg;

        case (cmd_reg)
            CMD_LEAF:
            begin
                if (leaf_reg >= 3'(LEAF_MAX))
                begin
                    code = STAT_LEAVES;
                end
                else
                begin
                    do_insert = 1'b1;
                    ins_tab   = LEAF_PAT[leaf_reg[1:0]];
                    leaf_next = leaf_reg + 3'd1;
                end
            end
            CMD_AND:
            begin
                if (!hit_l_reg || !hit_r_reg)
                begin
                    code = STAT_UNKNOWN;
                end
                else
                begin
                    do_insert = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // duplicate id keeps the first value
        if (do_insert && hit_n_reg)
        begin
            do_insert = 1'b0;
        end
        if (do_insert && (fill_reg == CNT_BITS'(STORE_DEPTH)))
        begin
            do_insert = 1'b0;
            code      = STAT_FULL;
        end
        if (do_insert)
        begin
            fill_next = fill_reg + 1'b1;
        end

        root_err = (err_reg != STAT_OK) ? err_reg :
                   (hit_n_reg ? STAT_OK : STAT_UNKNOWN);

        err_next = (err_reg == STAT_OK) ? code : err_reg;
        if (cmd_reg == CMD_ROOT)
        begin
            fill_next = '0;
            leaf_next = '0;
            err_next  = STAT_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && do_insert)
        begin
            slot_key_reg[fill_reg[IDX_BITS-1:0]] <= node_reg;
            slot_mem[fill_reg[IDX_BITS-1:0]]     <= ins_tab;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            leaf_reg  <= '0;
            err_reg   <= STAT_OK;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl.exec && (cmd_reg == CMD_ROOT);
            if (ctl.exec)
            begin
                fill_reg <= fill_next;
                leaf_reg <= leaf_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && (cmd_reg == CMD_ROOT))
        begin
            tt_reg   <= (root_err == STAT_OK) ? rd_a_reg : '0;
            stat_reg <= root_err;
        end
    end

    assign result_valid = valid_reg;
    assign truth_table  = tt_reg;
    assign status       = stat_reg;

endmodule

/* rtl/cut_truth_table_eval.sv */
// ----------------------------------------------------------------------------
// cut_truth_table_eval
// Truth table of a cut of up to four leaves in an and-inverter graph.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers on a clock edge with start high and busy low. cmd picks
//   leaf, and-node or root; the other fields carry ids and fanin inversions.
//   Each item passes capture, key compare with table memory read, then
//   combine and insert. No new item transfers while busy is high; the next
//   item transfers once busy drops.
//   Only a root item gives a result: result_valid pulses for one cycle with
//   truth_table and status, from the result register loaded in the execute
//   state. The receiver cannot stall; the result must be taken on that
//   cycle.
//   A root item also clears the store, the leaf count and the kept error.
//   Reset clears the counters and the error; the key/table store needs no
//   clearing pass since only filled slots are compared.
// ----------------------------------------------------------------------------
module cut_truth_table_eval (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [ctte_pkg::ID_BITS-1:0] node_id,
    input  logic [ctte_pkg::ID_BITS-1:0] left_id,
    input  logic                         left_inv,
    input  logic [ctte_pkg::ID_BITS-1:0] right_id,
    input  logic                         right_inv,
    output logic                         result_valid,
    output logic [ctte_pkg::TT_BITS-1:0] truth_table,
    output logic [1:0]                   status
);
    import ctte_pkg::*;

    ctl_t ctl;

    ctte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    ctte_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd          (cmd),
        .node_id      (node_id),
        .left_id      (left_id),
        .left_inv     (left_inv),
        .right_id     (right_id),
        .right_inv    (right_inv),
        .result_valid (result_valid),
        .truth_table  (truth_table),
        .status       (status)
    );

endmodule
